/* hw/rtl/cbm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	// bus access kinds
	localparam logic [1:0] CMD_ROM_READ  = 2'd0;
	localparam logic [1:0] CMD_REG_WRITE = 2'd1;
	localparam logic [1:0] CMD_RAM_READ  = 2'd2;
	localparam logic [1:0] CMD_RAM_WRITE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
	localparam logic [1:0] CFG_RAM_BANK_COUNT = 2'd1;

	// address map
	localparam logic [15:0] ENABLE_END    = 16'h1FFF;
	localparam logic [15:0] ROM_BANK_END  = 16'h3FFF;
	localparam logic [15:0] BANK_SEL_END  = 16'h5FFF;
	localparam logic [15:0] ROM_FIXED_END = 16'h3FFF;
	localparam logic [15:0] ROM_WIN_BASE  = 16'h4000;
	localparam logic [15:0] RAM_BASE      = 16'hA000;

	localparam int ROM_BANK_SHIFT = 14;
	localparam int RAM_BANK_SHIFT = 13;

	localparam logic [3:0]  RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0]  RAM_SEL_MAX    = 8'h03;
	localparam logic [7:0]  RTC_SEL_MIN    = 8'h08;
	localparam logic [7:0]  RTC_SEL_MAX    = 8'h0C;
	localparam logic [23:0] RTC_MARKER     = 24'hFFFFFF;

	// reset values
	localparam logic [7:0] ROM_COUNT_RESET = 8'd2;
	localparam logic [2:0] RAM_COUNT_RESET = 3'd1;
	localparam logic [6:0] ROM_BANK_RESET  = 7'd1;
	localparam logic [6:0] ROM_MOD_RESET   = 7'd1;

	// shift-subtract remainder: one dividend bit per step, MSB first
	localparam logic [2:0] MOD_MSB = 3'd6;

	typedef enum logic [0:0] {
		ST_READY,
		ST_MOD
	} state_t;

	typedef struct packed {
		logic       item_take;
		logic       cfg_take;
		logic       mod_clear;
		logic       mod_step;
		logic       mod_last;
		logic [2:0] mod_bit;
	} cmd_t;

	typedef struct packed {
		logic out_room;
		logic item_sets_bank;
		logic cfg_sets_count;
	} stat_t;

endpackage
`default_nettype wire

/* hw/rtl/cartridge_bank_mapper_unit.sv */
`default_nettype none
// Latency: a result appears in the output register in the cycle after its access transfers.
// Throughput: one access per cycle while results are taken; a waiting result holds off input.
// A ROM bank select write or a ROM bank count write starts the shift-subtract remainder
// unit, which retires one bank bit per cycle while input and config are held off.
// Reset (arst_n low): bank count 2, RAM bank count 1, ROM bank 1, RAM disabled, RTC mode.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_unit
// Translates cartridge bus accesses to ROM/RAM offsets through bank registers.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,  // [15:0] address, [23:16] data
	input  wire  [1:0]  s_axis_tuser,  // [1:0] command
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [27:0] mapped_address, [31:28] zero
	output logic [0:0]  m_axis_tuser,  // [0] valid_res
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [7:0]  cfg_data
);
	import cbm_pkg::*;

	cmd_t        cmd;
	stat_t       stat;
	logic        in_ready;
	logic        cfg_rdy;
	logic [27:0] mapped_address;
	logic        valid_res;

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.in_ready  (in_ready),
		.cfg_ready (cfg_rdy),
		.cmd       (cmd)
	);

	cbm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (s_axis_tuser),
		.address        (s_axis_tdata[15:0]),
		.data           (s_axis_tdata[23:16]),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.mapped_address (mapped_address),
		.valid_res      (valid_res)
	);

	assign s_axis_tready   = in_ready;
	assign cfg_ready       = cfg_rdy;
	assign m_axis_tdata    = {4'b0000, mapped_address};
	assign m_axis_tuser[0] = valid_res;

endmodule
`default_nettype wire

/* hw/rtl/cbm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_ctrl
// Controller: handshakes and the sequencing of the bank remainder steps.
// ----------------------------------------------------------------------------
module cbm_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	input  wire           cfg_valid,
	input  cbm_pkg::stat_t stat,
	output logic          in_ready,
	output logic          cfg_ready,
	output cbm_pkg::cmd_t cmd
);
	import cbm_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] step_q;
	logic       restart;

	always_comb begin
		in_ready      = 1'b0;
		cfg_ready     = 1'b0;
		cmd           = '0;
		cmd.mod_bit   = MOD_MSB - step_q;
		cmd.mod_last  = 1'b0;
		case (state_q)
			ST_READY: begin
				in_ready      = stat.out_room;
				cfg_ready     = 1'b1;
				cmd.item_take = in_valid && stat.out_room;
				cmd.cfg_take  = cfg_valid;
				cmd.mod_clear = restart;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				cmd.mod_last = (step_q == MOD_MSB);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// a new bank or bank count needs a fresh remainder
	assign restart = (in_valid && stat.out_room && stat.item_sets_bank)
		|| (cfg_valid && stat.cfg_sets_count);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_READY: begin
				if (restart) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (step_q == MOD_MSB) begin
					state_d = ST_READY;
				end
			end
			default: begin
				state_d = ST_READY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			// advance only while the sequence continues, so the count rests at zero
			if ((state_q == ST_MOD) && (state_d == ST_MOD)) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (!in_ready && !cfg_ready))
		else $error("transfer offered while remainder busy");

	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mod_clear) |=> ##6 (cmd.mod_last))
		else $error("remainder sequence length wrong");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mod_last) |=> (state_q == ST_READY))
		else $error("controller did not return after last step");
`endif

endmodule
`default_nettype wire

/* hw/rtl/cbm_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_datapath
// Bank registers, shift-subtract remainder unit and address translation.
// ----------------------------------------------------------------------------
module cbm_datapath (
	input  wire           clk,
	input  wire           arst_n,
	input  wire  [1:0]    command,
	input  wire  [15:0]   address,
	input  wire  [7:0]    data,
	input  wire  [1:0]    cfg_index,
	input  wire  [7:0]    cfg_data,
	input  cbm_pkg::cmd_t cmd,
	output cbm_pkg::stat_t stat,
	output logic          out_valid,
	input  wire           out_ready,
	output logic [27:0]   mapped_address,
	output logic          valid_res
);
	import cbm_pkg::*;

	logic [7:0]  rom_count_q;
	logic [2:0]  ram_count_q;
	logic [3:0]  enable_q;
	logic [6:0]  rom_bank_q;
	logic [1:0]  ram_bank_q;
	logic        ram_mode_q;
	logic [3:0]  rtc_sel_q;
	logic [6:0]  rem_q;

	logic        out_valid_q;
	logic [27:0] out_addr_q;
	logic        out_ok_q;

	logic [8:0]  divisor;
	logic [7:0]  trial;
	logic [8:0]  diff;
	logic [6:0]  rem_next;
	logic [15:0] rom_off;
	logic [15:0] ram_off;
	logic [27:0] res_addr;
	logic        res_ok;
	logic [6:0]  bank_wr;

	// count of zero stands for 256 banks
	assign divisor  = {(rom_count_q == 8'd0), rom_count_q};
	assign trial    = {rem_q, rom_bank_q[cmd.mod_bit]};
	assign diff     = {1'b0, trial} - divisor;
	assign rem_next = ({1'b0, trial} >= divisor) ? diff[6:0] : trial[6:0];

	assign bank_wr  = (data[6:0] == 7'd0) ? ROM_BANK_RESET : data[6:0];

	assign stat.out_room       = !out_valid_q || out_ready;
	assign stat.item_sets_bank = (command == CMD_REG_WRITE)
		&& (address > ENABLE_END) && (address <= ROM_BANK_END);
	assign stat.cfg_sets_count = (cfg_index == CFG_ROM_BANK_COUNT);

	assign rom_off = address - ROM_WIN_BASE;
	assign ram_off = address - RAM_BASE;

	always_comb begin
		res_addr = '0;
		res_ok   = 1'b1;
		case (command)
			CMD_ROM_READ: begin
				if (address <= ROM_FIXED_END) begin
					res_addr = 28'(address);
				end else begin
					res_addr = 28'(rom_off) + (28'(rem_q) << ROM_BANK_SHIFT);
				end
			end
			CMD_REG_WRITE: begin
				res_addr = '0;
			end
			CMD_RAM_READ, CMD_RAM_WRITE: begin
				if (enable_q != RAM_ENABLE_KEY) begin
					res_ok = 1'b0;
				end else if (!ram_mode_q) begin
					res_addr = {rtc_sel_q, RTC_MARKER};
				end else if (ram_count_q > 3'd1) begin
					res_addr = 28'(ram_off) + (28'(ram_bank_q) << RAM_BANK_SHIFT);
				end else if (ram_count_q == 3'd1) begin
					res_addr = 28'(ram_off);
				end else begin
					res_ok = 1'b0;
				end
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_count_q <= ROM_COUNT_RESET;
			ram_count_q <= RAM_COUNT_RESET;
			enable_q    <= '0;
			rom_bank_q  <= ROM_BANK_RESET;
			ram_bank_q  <= '0;
			ram_mode_q  <= 1'b0;
			rtc_sel_q   <= '0;
			rem_q       <= ROM_MOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_take) begin
				case (cfg_index)
					CFG_ROM_BANK_COUNT: rom_count_q <= cfg_data;
					CFG_RAM_BANK_COUNT: ram_count_q <= cfg_data[2:0];
					default: begin
						rom_count_q <= rom_count_q;
					end
				endcase
			end
			if (cmd.item_take && (command == CMD_REG_WRITE)) begin
				if (address <= ENABLE_END) begin
					enable_q <= data[3:0];
				end else if (address <= ROM_BANK_END) begin
					rom_bank_q <= bank_wr;
				end else if (address <= BANK_SEL_END) begin
					if (data <= RAM_SEL_MAX) begin
						ram_mode_q <= 1'b1;
						ram_bank_q <= data[1:0];
					end else if ((data >= RTC_SEL_MIN) && (data <= RTC_SEL_MAX)) begin
						ram_mode_q <= 1'b0;
						rtc_sel_q  <= data[3:0];
					end
				end
			end
			if (cmd.mod_clear) begin
				rem_q <= '0;
			end else if (cmd.mod_step) begin
				rem_q <= rem_next;
			end
			if (cmd.item_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.item_take) begin
			out_addr_q <= res_addr;
			out_ok_q   <= res_ok;
		end
	end

	assign out_valid      = out_valid_q;
	assign mapped_address = out_addr_q;
	assign valid_res      = out_ok_q;

`ifndef ASSERT_OFF
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mod_last) |=> ({2'b00, rem_q} < divisor) && (rem_q <= rom_bank_q))
		else $error("bank remainder out of range");

	a_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rom_bank_q != 7'd0))
		else $error("ROM bank register holds zero");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.item_take) |=> (out_valid_q))
		else $error("accepted access left no result");
`endif

endmodule
`default_nettype wire
